FILE: design/pva_pkg.sv
// Package for the polyphonic voice allocator.
// Holds the payload structs, the scan record carried along the channel cells, and codes.
// No dependencies.
package pva_pkg;

    localparam int KEY_W        = 5;
    localparam int NOTE_W       = 5;
    localparam int TIME_W       = 32;
    localparam int CHAN_IDX_W   = 5;
    localparam int COUNT_W      = 6;
    localparam int ACT_W        = 4;
    localparam int CHAN_OUT_W   = 3;
    localparam int NOTE_OUT_W   = 6;
    localparam int MASK_W       = 8;

    localparam int DEF_NUM_KEYS     = 32;
    localparam int DEF_MAX_CHANNELS = 8;

    localparam logic [ACT_W-1:0]      ACT_RESET   = 4'd8;
    localparam logic [NOTE_OUT_W-1:0] NOTE_OFFSET = 6'd24;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        OUT_NO_CHANGE = 3'd0,
        OUT_ASSIGNED  = 3'd1,
        OUT_STOLEN    = 3'd2,
        OUT_NO_CHAN   = 3'd3,
        OUT_RELEASED  = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic              key_down;
        logic [TIME_W-1:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]            outcome;
        logic [CHAN_OUT_W-1:0] channel;
        logic [NOTE_OUT_W-1:0] note_out;
        logic [MASK_W-1:0]     gate_mask;
        logic [MASK_W-1:0]     released_mask;
    } t_out;

    typedef struct packed {
        t_op                   op;
        logic [NOTE_W-1:0]     key;
        logic [TIME_W-1:0]     stamp;
        logic [COUNT_W-1:0]    n_active;
        logic                  has_best;
        logic [CHAN_IDX_W-1:0] best_idx;
        logic [TIME_W-1:0]     best_time;
        logic                  has_back;
        logic [CHAN_IDX_W-1:0] back_idx;
        logic [NOTE_W-1:0]     back_note;
    } t_scan;

    typedef struct packed {
        logic                  en;
        logic [CHAN_IDX_W-1:0] idx;
        logic [NOTE_W-1:0]     note;
    } t_commit;

endpackage

FILE: design/poly_voice_allocator.sv
// Polyphonic voice allocator top level: key state, channel cell chain, result register.
// Depends on pva_pkg and pva_cell.
//
// Input channel: i_valid / o_stall carry one key report per transaction
// (key index, up or down, millisecond stamp). Output channel: o_valid /
// i_stall carry one result per report: outcome, channel, note, gate mask
// and released mask.
// A report walks a chain of MAX_CHANNELS channel cells, one cell per cycle;
// each cell updates the free and busy candidates and applies a release on
// a note match. The last cell's record is registered into r_fin; in the FIN
// state, once the output register is free, the allocator picks the channel,
// writes it and loads the result register. One report is in flight at a
// time: o_stall stays high from acceptance until its result is loaded.
// The next report is taken while a result still waits in the output register;
// a stalled result holds, and the following report then waits at the end of
// its walk until the register frees. Reset clears key state, all channel
// notes, gates and release times, and sets active_channels to 8. i_cfg_we
// writes active_channels; the user must do this only while idle, since the
// block itself does not enforce it.
module poly_voice_allocator #(
    parameter int NUM_KEYS     = pva_pkg::DEF_NUM_KEYS,
    parameter int MAX_CHANNELS = pva_pkg::DEF_MAX_CHANNELS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  pva_pkg::t_in            i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output pva_pkg::t_out           o_data,
    input  logic                    i_cfg_we,
    input  logic [pva_pkg::ACT_W-1:0] i_cfg_data
);
    import pva_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                r_state;
    logic [ACT_W-1:0]      r_active;
    logic [NUM_KEYS-1:0]   r_key_held;
    t_scan                 r_fin;
    logic                  r_out_valid;
    t_out                  r_out;
    t_out                  n_out;

    t_scan                 start_rec;
    t_commit               commit;
    logic                  accept;
    logic                  out_free;
    logic                  in_range;
    logic [KW-1:0]         key_idx;
    logic                  held;
    logic [COUNT_W-1:0]    n_clamped;

    logic [MAX_CHANNELS:0] rec_valid;
    t_scan                 rec [MAX_CHANNELS+1];
    logic [MAX_CHANNELS-1:0] gate_vec;
    logic [MAX_CHANNELS-1:0] gate_after;
    logic [MAX_CHANNELS-1:0] rel_vec;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign in_range  = (32'(i_data.key_index) < 32'(NUM_KEYS));
    assign key_idx   = KW'(i_data.key_index);
    assign held      = r_key_held[key_idx];
    assign n_clamped = (COUNT_W'(r_active) > COUNT_W'(MAX_CHANNELS)) ?
                       COUNT_W'(MAX_CHANNELS) : COUNT_W'(r_active);

    always_comb begin
        start_rec           = '0;
        start_rec.op        = OP_NONE;
        start_rec.key       = i_data.key_index;
        start_rec.stamp     = i_data.time_ms;
        start_rec.n_active  = n_clamped;
        if (in_range && (held != i_data.key_down)) begin
            start_rec.op = i_data.key_down ? OP_PRESS : OP_RELEASE;
        end
    end

    assign rec_valid[0] = accept;
    assign rec[0]       = start_rec;

    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
        pva_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (accept),
            .i_rec_valid(rec_valid[g]),
            .i_rec      (rec[g]),
            .i_commit   (commit),
            .o_rec_valid(rec_valid[g+1]),
            .o_rec      (rec[g+1]),
            .o_gate     (gate_vec[g]),
            .o_rel      (rel_vec[g])
        );
        assign gate_after[g] = gate_vec[g] ||
                               (commit.en && (commit.idx == CHAN_IDX_W'(g)));
    end

    always_comb begin
        commit        = '0;
        n_out         = '0;
        n_out.outcome = OUT_NO_CHANGE;
        unique case (r_fin.op)
            OP_PRESS: begin
                if (r_fin.has_best) begin
                    n_out.outcome = OUT_ASSIGNED;
                    commit.idx    = r_fin.best_idx;
                    commit.en     = 1'b1;
                end else if (r_fin.has_back) begin
                    n_out.outcome = OUT_STOLEN;
                    commit.idx    = r_fin.back_idx;
                    commit.en     = 1'b1;
                end else begin
                    n_out.outcome = OUT_NO_CHAN;
                end
            end
            OP_RELEASE: begin
                n_out.outcome = OUT_RELEASED;
            end
            default: begin
                n_out.outcome = OUT_NO_CHANGE;
            end
        endcase
        commit.note = r_fin.key;
        if (commit.en) begin
            n_out.channel  = CHAN_OUT_W'(commit.idx);
            n_out.note_out = NOTE_OUT_W'(r_fin.key) + NOTE_OFFSET;
        end
        n_out.gate_mask     = MASK_W'(gate_after);
        n_out.released_mask = MASK_W'(rel_vec);
        commit.en           = commit.en && (r_state == S_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACT_RESET;
            r_key_held  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (accept && (start_rec.op != OP_NONE)) begin
                r_key_held[key_idx] <= i_data.key_down;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rec_valid[MAX_CHANNELS]) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_valid[MAX_CHANNELS]) begin
            r_fin <= rec[MAX_CHANNELS];
        end
        if ((r_state == S_FIN) && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: design/pva_cell.sv
// One voice channel cell: note, gate and release time of a single channel.
// Updates the scan record passing through and applies releases and assignments.
// Depends on pva_pkg.
module pva_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_rec_valid,
    input  pva_pkg::t_scan   i_rec,
    input  pva_pkg::t_commit i_commit,
    output logic             o_rec_valid,
    output pva_pkg::t_scan   o_rec,
    output logic             o_gate,
    output logic             o_rel
);
    import pva_pkg::*;

    logic [NOTE_W-1:0] r_note;
    logic              r_gate;
    logic [TIME_W-1:0] r_time;
    logic              r_rel;
    logic              r_rec_valid;
    t_scan             r_rec;
    t_scan             n_rec;
    logic              active;
    logic              rel_hit;
    logic              commit_hit;

    assign active     = i_rec_valid && (COUNT_W'(CELL_IDX) < i_rec.n_active);
    assign rel_hit    = active && (i_rec.op == OP_RELEASE) && (r_note == i_rec.key);
    assign commit_hit = i_commit.en && (i_commit.idx == CHAN_IDX_W'(CELL_IDX));

    always_comb begin
        n_rec = i_rec;
        if (active && (i_rec.op == OP_PRESS)) begin
            if (!r_gate) begin
                if (!i_rec.has_best || (r_time < i_rec.best_time)) begin
                    n_rec.has_best  = 1'b1;
                    n_rec.best_idx  = CHAN_IDX_W'(CELL_IDX);
                    n_rec.best_time = r_time;
                end
            end else begin
                if (!i_rec.has_back || (r_note < i_rec.back_note)) begin
                    n_rec.has_back  = 1'b1;
                    n_rec.back_idx  = CHAN_IDX_W'(CELL_IDX);
                    n_rec.back_note = r_note;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note      <= '0;
            r_gate      <= 1'b0;
            r_time      <= '0;
            r_rel       <= 1'b0;
            r_rec_valid <= 1'b0;
        end else begin
            r_rec_valid <= i_rec_valid;
            if (rel_hit) begin
                r_gate <= 1'b0;
                r_time <= i_rec.stamp;
                r_rel  <= 1'b1;
            end else if (i_start) begin
                r_rel <= 1'b0;
            end
            if (commit_hit) begin
                r_note <= i_commit.note;
                r_gate <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;
    assign o_gate      = r_gate;
    assign o_rel       = r_rel;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for poly_voice_allocator: drives key reports and register writes,
// predicts every result in a scoreboard class and compares it field by field.
// Depends on pva_pkg and the poly_voice_allocator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_VOICES  = DEF_MAX_CHANNELS;

    class voice_alloc_board;
        logic              held_keys [DEF_NUM_KEYS];
        logic [NOTE_W-1:0] voice_note [NUM_VOICES];
        logic              voice_gate [NUM_VOICES];
        logic [TIME_W-1:0] voice_stamp [NUM_VOICES];
        logic [ACT_W-1:0]  active;
        t_out              due_results [$];
        int                mismatches;

        function new();
            foreach (held_keys[k]) held_keys[k] = 1'b0;
            foreach (voice_note[j]) begin
                voice_note[j]  = '0;
                voice_gate[j]  = 1'b0;
                voice_stamp[j] = '0;
            end
            active     = ACT_RESET;
            mismatches = 0;
        endfunction

        function void note_key_report(t_in r);
            int   n;
            int   best;
            int   backup;
            int   c;
            t_out res;
            n      = (active > NUM_VOICES) ? NUM_VOICES : int'(active);
            best   = -1;
            backup = -1;
            res    = '0;
            if (held_keys[r.key_index] != r.key_down) begin
                if (r.key_down) begin
                    held_keys[r.key_index] = 1'b1;
                    for (int j = 0; j < n; j++) begin
                        if (!voice_gate[j]) begin
                            if (best < 0 || voice_stamp[j] < voice_stamp[best])
                                best = j;
                        end else begin
                            if (backup < 0 || voice_note[j] < voice_note[backup])
                                backup = j;
                        end
                    end
                    if (best >= 0 || backup >= 0) begin
                        c              = (best >= 0) ? best : backup;
                        res.outcome    = (best >= 0) ? OUT_ASSIGNED : OUT_STOLEN;
                        voice_note[c]  = r.key_index;
                        voice_gate[c]  = 1'b1;
                        res.channel    = CHAN_OUT_W'(c);
                        res.note_out   = NOTE_OUT_W'(r.key_index) + NOTE_OFFSET;
                    end else begin
                        res.outcome = OUT_NO_CHAN;
                    end
                end else begin
                    held_keys[r.key_index] = 1'b0;
                    res.outcome = OUT_RELEASED;
                    for (int j = 0; j < n; j++) begin
                        if (voice_note[j] == r.key_index) begin
                            voice_gate[j]        = 1'b0;
                            voice_stamp[j]       = r.time_ms;
                            res.released_mask[j] = 1'b1;
                        end
                    end
                end
            end
            for (int j = 0; j < NUM_VOICES; j++)
                res.gate_mask[j] = voice_gate[j];
            due_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_voice_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = due_results.pop_front();
                compare_field("outcome", 8'(want.outcome), 8'(got.outcome));
                compare_field("channel", 8'(want.channel), 8'(got.channel));
                compare_field("note_out", 8'(want.note_out), 8'(got.note_out));
                compare_field("gate_mask", want.gate_mask, got.gate_mask);
                compare_field("released_mask", want.released_mask, got.released_mask);
            end
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_stall;
    t_in               i_data     = '0;
    logic              o_valid;
    logic              i_stall    = 1'b0;
    t_out              o_data;
    logic              i_cfg_we   = 1'b0;
    logic [ACT_W-1:0]  i_cfg_data = '0;

    voice_alloc_board  sb;
    bit                tx_idle_on = 1'b1;
    bit                rx_idle_on = 1'b1;
    logic [TIME_W-1:0] now_ms     = '0;
    int                quiet_cycles = 0;

    poly_voice_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_voice_result(o_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!rx_idle_on)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_report(input t_in r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (o_stall);
        sb.note_key_report(r);
    endtask

    task automatic send_key(input int key, input bit down, input logic [TIME_W-1:0] stamp);
        t_in r;
        r.key_index = KEY_W'(key);
        r.key_down  = down;
        r.time_ms   = stamp;
        send_report(r);
    endtask

    task automatic idle_tx(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic wait_results_done();
        idle_tx(1);
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] value);
        wait_results_done();
        repeat (12) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.active = value;
    endtask

    function automatic t_in random_report();
        t_in r;
        if ($urandom_range(0, 3) == 0)
            r.key_index = KEY_W'($urandom_range(0, 31));
        else
            r.key_index = KEY_W'($urandom_range(0, 11));
        if ($urandom_range(0, 3) != 0)
            r.key_down = !sb.held_keys[r.key_index];
        else
            r.key_down = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 31) == 0)
            now_ms = $urandom;
        else
            now_ms = now_ms + $urandom_range(0, 40);
        r.time_ms = now_ms;
        return r;
    endfunction

    task automatic run_phase(input logic [ACT_W-1:0] value, input int count,
                             input bit idling, input int pause_at);
        write_active(value);
        tx_idle_on = idling;
        rx_idle_on = idling;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                wait_results_done();
            if (tx_idle_on && $urandom_range(0, 7) == 0)
                idle_tx($urandom_range(1, 18));
            send_report(random_report());
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_key(5, 1'b0, 32'd0);
        send_key(0, 1'b1, 32'd0);
        send_key(0, 1'b1, 32'd0);
        send_key(0, 1'b0, 32'hFFFF_FFFF);
        send_key(31, 1'b1, 32'd1);
        for (int k = 1; k < 8; k++)
            send_key(k, 1'b1, 32'd2);
        send_key(8, 1'b1, 32'd3);
        send_key(1, 1'b0, 32'd5);
        send_key(8, 1'b0, 32'd100);
        send_key(3, 1'b0, 32'd50);
        send_key(9, 1'b1, 32'd60);
        send_key(31, 1'b0, 32'd0);
        send_key(10, 1'b1, 32'd70);

        write_active(4'd0);
        send_key(20, 1'b1, 32'd80);
        send_key(20, 1'b0, 32'd90);
        send_key(9, 1'b0, 32'd95);

        run_phase(4'd15, 50, 1'b1, -1);
        run_phase(4'd1, 40, 1'b1, 20);
        run_phase(4'd3, 50, 1'b1, -1);
        run_phase(4'd0, 20, 1'b1, -1);
        run_phase(4'd9, 50, 1'b1, -1);
        run_phase(4'd5, 50, 1'b1, -1);
        run_phase(4'd2, 40, 1'b1, -1);
        run_phase(4'd8, 80, 1'b0, -1);

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
